[hw/rtl/rv64_instruction_classifier_unit_macros.svh]
// Assertion macros used by the instruction classifier RTL.
`ifndef RV64_INSTRUCTION_CLASSIFIER_UNIT_MACROS_SVH
`define RV64_INSTRUCTION_CLASSIFIER_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset.
`define RV64IC_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("rv64ic assertion failed");

// Next-cycle implication, checked out of reset.
`define RV64IC_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("rv64ic assertion failed");

`else

`define RV64IC_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons)
`define RV64IC_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons)

`endif

`endif

[hw/rtl/rv64ic_pkg.sv]
// Types and constants of the RV64IMAC instruction classifier.
package rv64ic_pkg;

    // Dense mnemonic numbering; members count up from zero in listing order.
    typedef enum logic [7:0]
    {
        MN_ILLEGAL, MN_UNKNOWN,
        MN_C_ADDI4SPN, MN_C_FLD, MN_C_LW, MN_C_LD, MN_C_FSD, MN_C_SW, MN_C_SD,
        MN_C_NOP, MN_C_ADDI, MN_C_ADDIW, MN_C_LI, MN_C_ADDI16SP, MN_C_LUI,
        MN_C_SRLI64, MN_C_SRLI, MN_C_SRAI64, MN_C_SRAI, MN_C_ANDI, MN_C_SUB,
        MN_C_XOR, MN_C_OR, MN_C_AND, MN_C_SUBW, MN_C_ADDW, MN_C_J, MN_C_BEQZ,
        MN_C_BNEZ, MN_C_SLLI64, MN_C_SLLI, MN_C_FLDSP, MN_C_LWSP, MN_C_LDSP,
        MN_C_JR, MN_C_MV, MN_C_EBREAK, MN_C_JALR, MN_C_ADD, MN_C_FSDSP, MN_C_SWSP,
        MN_C_SDSP,
        MN_LB, MN_LH, MN_LW, MN_LD, MN_LBU, MN_LHU, MN_LWU, MN_ADDI,
        MN_SLLI, MN_SLTI, MN_SLTIU, MN_XORI, MN_SRLI, MN_SRAI, MN_ORI, MN_ANDI,
        MN_AUIPC, MN_ADDIW, MN_SLLIW, MN_SRLIW, MN_SRAIW, MN_SB, MN_SH, MN_SW, MN_SD,
        MN_AMOADD_W, MN_AMOSWAP_W, MN_LR_W, MN_SC_W, MN_AMOXOR_W, MN_AMOOR_W,
        MN_AMOAND_W, MN_AMOMIN_W, MN_AMOMAX_W, MN_AMOMINU_W, MN_AMOMAXU_W,
        MN_AMOADD_D, MN_AMOSWAP_D, MN_LR_D, MN_SC_D, MN_AMOXOR_D, MN_AMOOR_D,
        MN_AMOAND_D, MN_AMOMIN_D, MN_AMOMAX_D, MN_AMOMINU_D, MN_AMOMAXU_D,
        MN_ADD, MN_MUL, MN_SUB, MN_SLL, MN_MULH, MN_SLT, MN_MULHSU, MN_SLTU,
        MN_MULHU, MN_XOR, MN_DIV, MN_SRL, MN_DIVU, MN_SRA, MN_OR, MN_REM, MN_AND,
        MN_REMU, MN_LUI, MN_ADDW, MN_MULW, MN_SUBW, MN_SLLW, MN_DIVW, MN_SRLW,
        MN_DIVUW, MN_SRAW, MN_REMW, MN_REMUW, MN_BEQ, MN_BNE, MN_BLT, MN_BGE,
        MN_BLTU, MN_BGEU, MN_JALR, MN_JAL, MN_ECALL, MN_EBREAK, MN_URET, MN_SRET,
        MN_HRET, MN_MRET, MN_CSRRW, MN_CSRRS, MN_CSRRC, MN_CSRRWI, MN_CSRRSI,
        MN_CSRRCI
    } mnemonic_t;

    // Major opcodes, bits 6:2 of a 32-bit word.
    localparam logic [4:0] OPC_LOAD      = 5'h00;
    localparam logic [4:0] OPC_OP_IMM    = 5'h04;
    localparam logic [4:0] OPC_AUIPC     = 5'h05;
    localparam logic [4:0] OPC_OP_IMM_32 = 5'h06;
    localparam logic [4:0] OPC_STORE     = 5'h08;
    localparam logic [4:0] OPC_AMO       = 5'h0B;
    localparam logic [4:0] OPC_OP        = 5'h0C;
    localparam logic [4:0] OPC_LUI       = 5'h0D;
    localparam logic [4:0] OPC_OP_32     = 5'h0E;
    localparam logic [4:0] OPC_BRANCH    = 5'h18;
    localparam logic [4:0] OPC_JALR      = 5'h19;
    localparam logic [4:0] OPC_JAL       = 5'h1B;
    localparam logic [4:0] OPC_SYSTEM    = 5'h1C;

    // funct7 / funct6 selectors.
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MUL  = 7'h01;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [5:0] F6_SRL  = 6'h00;
    localparam logic [5:0] F6_SRA  = 6'h10;

    // AMO funct5 codes.
    localparam logic [4:0] AMO_ADD  = 5'h00;
    localparam logic [4:0] AMO_SWAP = 5'h01;
    localparam logic [4:0] AMO_LR   = 5'h02;
    localparam logic [4:0] AMO_SC   = 5'h03;
    localparam logic [4:0] AMO_XOR  = 5'h04;
    localparam logic [4:0] AMO_OR   = 5'h08;
    localparam logic [4:0] AMO_AND  = 5'h0C;
    localparam logic [4:0] AMO_MIN  = 5'h10;
    localparam logic [4:0] AMO_MAX  = 5'h14;
    localparam logic [4:0] AMO_MINU = 5'h18;
    localparam logic [4:0] AMO_MAXU = 5'h1C;

    // Exact privileged words under SYSTEM with funct3 zero.
    localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
    localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
    localparam logic [31:0] WORD_URET   = 32'h0020_0073;
    localparam logic [31:0] WORD_SRET   = 32'h1020_0073;
    localparam logic [31:0] WORD_HRET   = 32'h2020_0073;
    localparam logic [31:0] WORD_MRET   = 32'h3020_0073;

    // Compressed quadrants and the 32-bit marker in bits 1:0.
    localparam logic [1:0] QUAD_0    = 2'd0;
    localparam logic [1:0] QUAD_1    = 2'd1;
    localparam logic [1:0] QUAD_FULL = 2'd3;

    typedef struct packed
    {
        mnemonic_t code;
        logic      compressed;
    } result_t;

endpackage

[hw/rtl/rv64ic_decode.sv]
// Combinational decode of one instruction word into a mnemonic code.
module rv64ic_decode
    import rv64ic_pkg::*;
(
    input  logic [31:0] instruction,
    output result_t     result
);

    logic [1:0]  quad;
    logic [2:0]  c_f3;
    logic        c_b12;
    logic [4:0]  c_rd;
    logic [4:0]  c_rs2;
    logic [10:0] c_lo11;
    logic [1:0]  c_f2;
    logic [1:0]  c_sel;
    logic        c_zero_sh;
    logic [4:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [5:0]  f6;
    logic [4:0]  f5;
    logic        amo_d;
    mnemonic_t   c_code;
    mnemonic_t   f_code;
    mnemonic_t   amo_code;

    assign quad      = instruction[1:0];
    assign c_f3      = instruction[15:13];
    assign c_b12     = instruction[12];
    assign c_rd      = instruction[11:7];
    assign c_rs2     = instruction[6:2];
    assign c_lo11    = instruction[12:2];
    assign c_f2      = instruction[6:5];
    assign c_sel     = instruction[11:10];
    assign c_zero_sh = !c_b12 && (c_rs2 == 5'd0);

    assign opc   = instruction[6:2];
    assign f3    = instruction[14:12];
    assign f7    = instruction[31:25];
    assign f6    = instruction[31:26];
    assign f5    = instruction[31:27];
    assign amo_d = f3[0];

    // Compressed quadrants.
    always_comb
    begin
        c_code = MN_ILLEGAL;
        if (quad == QUAD_0)
        begin
            case (c_f3)
                3'd0: c_code = (c_lo11 == 11'd0) ? MN_ILLEGAL : MN_C_ADDI4SPN;
                3'd1: c_code = MN_C_FLD;
                3'd2: c_code = MN_C_LW;
                3'd3: c_code = MN_C_LD;
                3'd5: c_code = MN_C_FSD;
                3'd6: c_code = MN_C_SW;
                3'd7: c_code = MN_C_SD;
                default: c_code = MN_ILLEGAL;
            endcase
        end
        else if (quad == QUAD_1)
        begin
            case (c_f3)
                3'd0: c_code = (c_lo11 == 11'd0) ? MN_C_NOP : MN_C_ADDI;
                3'd1: c_code = (c_rd == 5'd0) ? MN_ILLEGAL : MN_C_ADDIW;
                3'd2: c_code = (c_rd == 5'd0) ? MN_ILLEGAL : MN_C_LI;
                3'd3:
                begin
                    if (c_rd == 5'd2)
                        c_code = MN_C_ADDI16SP;
                    else if (c_rd != 5'd0)
                        c_code = MN_C_LUI;
                    else
                        c_code = MN_ILLEGAL;
                end
                3'd4:
                begin
                    case (c_sel)
                        2'd0: c_code = c_zero_sh ? MN_C_SRLI64 : MN_C_SRLI;
                        2'd1: c_code = c_zero_sh ? MN_C_SRAI64 : MN_C_SRAI;
                        2'd2: c_code = MN_C_ANDI;
                        default:
                        begin
                            case ({c_b12, c_f2})
                                3'b000: c_code = MN_C_SUB;
                                3'b001: c_code = MN_C_XOR;
                                3'b010: c_code = MN_C_OR;
                                3'b011: c_code = MN_C_AND;
                                3'b100: c_code = MN_C_SUBW;
                                3'b101: c_code = MN_C_ADDW;
                                default: c_code = MN_ILLEGAL;
                            endcase
                        end
                    endcase
                end
                3'd5: c_code = MN_C_J;
                3'd6: c_code = MN_C_BEQZ;
                default: c_code = MN_C_BNEZ;
            endcase
        end
        else
        begin
            case (c_f3)
                3'd0: c_code = (!c_b12 && c_f2 == 2'd0) ? MN_C_SLLI64 : MN_C_SLLI;
                3'd1: c_code = MN_C_FLDSP;
                3'd2: c_code = MN_C_LWSP;
                3'd3: c_code = MN_C_LDSP;
                3'd4:
                begin
                    if (!c_b12)
                        c_code = (c_rs2 == 5'd0) ? MN_C_JR : MN_C_MV;
                    else if (c_rs2 == 5'd0 && c_rd == 5'd0)
                        c_code = MN_C_EBREAK;
                    else if (c_rs2 == 5'd0)
                        c_code = MN_C_JALR;
                    else
                        c_code = MN_C_ADD;
                end
                3'd5: c_code = MN_C_FSDSP;
                3'd6: c_code = MN_C_SWSP;
                default: c_code = MN_C_SDSP;
            endcase
        end
    end

    // Atomics: funct5 picks the operation, funct3 bit 0 picks word or doubleword.
    always_comb
    begin
        case (f5)
            AMO_ADD:  amo_code = amo_d ? MN_AMOADD_D : MN_AMOADD_W;
            AMO_SWAP: amo_code = amo_d ? MN_AMOSWAP_D : MN_AMOSWAP_W;
            AMO_LR:
            begin
                if (instruction[24:20] != 5'd0)
                    amo_code = MN_ILLEGAL;
                else
                    amo_code = amo_d ? MN_LR_D : MN_LR_W;
            end
            AMO_SC:   amo_code = amo_d ? MN_SC_D : MN_SC_W;
            AMO_XOR:  amo_code = amo_d ? MN_AMOXOR_D : MN_AMOXOR_W;
            AMO_OR:   amo_code = amo_d ? MN_AMOOR_D : MN_AMOOR_W;
            AMO_AND:  amo_code = amo_d ? MN_AMOAND_D : MN_AMOAND_W;
            AMO_MIN:  amo_code = amo_d ? MN_AMOMIN_D : MN_AMOMIN_W;
            AMO_MAX:  amo_code = amo_d ? MN_AMOMAX_D : MN_AMOMAX_W;
            AMO_MINU: amo_code = amo_d ? MN_AMOMINU_D : MN_AMOMINU_W;
            AMO_MAXU: amo_code = amo_d ? MN_AMOMAXU_D : MN_AMOMAXU_W;
            default:  amo_code = MN_ILLEGAL;
        endcase
    end

    // 32-bit words.
    always_comb
    begin
        f_code = MN_ILLEGAL;
        case (opc)
            OPC_LOAD:
            begin
                case (f3)
                    3'd0: f_code = MN_LB;
                    3'd1: f_code = MN_LH;
                    3'd2: f_code = MN_LW;
                    3'd3: f_code = MN_LD;
                    3'd4: f_code = MN_LBU;
                    3'd5: f_code = MN_LHU;
                    3'd6: f_code = MN_LWU;
                    default: f_code = MN_ILLEGAL;
                endcase
            end
            OPC_OP_IMM:
            begin
                case (f3)
                    3'd0: f_code = MN_ADDI;
                    3'd1: f_code = MN_SLLI;
                    3'd2: f_code = MN_SLTI;
                    3'd3: f_code = MN_SLTIU;
                    3'd4: f_code = MN_XORI;
                    3'd5:
                    begin
                        if (f6 == F6_SRL)
                            f_code = MN_SRLI;
                        else if (f6 == F6_SRA)
                            f_code = MN_SRAI;
                        else
                            f_code = MN_ILLEGAL;
                    end
                    3'd6: f_code = MN_ORI;
                    default: f_code = MN_ANDI;
                endcase
            end
            OPC_AUIPC: f_code = MN_AUIPC;
            OPC_OP_IMM_32:
            begin
                if (f3 == 3'd0)
                    f_code = MN_ADDIW;
                else if (f3 == 3'd1)
                    f_code = MN_SLLIW;
                else if (f3 == 3'd5 && f7 == F7_BASE)
                    f_code = MN_SRLIW;
                else if (f3 == 3'd5 && f7 == F7_ALT)
                    f_code = MN_SRAIW;
                else
                    f_code = MN_ILLEGAL;
            end
            OPC_STORE:
            begin
                case (f3)
                    3'd0: f_code = MN_SB;
                    3'd1: f_code = MN_SH;
                    3'd2: f_code = MN_SW;
                    3'd3: f_code = MN_SD;
                    default: f_code = MN_ILLEGAL;
                endcase
            end
            OPC_AMO: f_code = (f3 inside {3'd2, 3'd3}) ? amo_code : MN_ILLEGAL;
            OPC_OP:
            begin
                if (f7 == F7_BASE)
                begin
                    case (f3)
                        3'd0: f_code = MN_ADD;
                        3'd1: f_code = MN_SLL;
                        3'd2: f_code = MN_SLT;
                        3'd3: f_code = MN_SLTU;
                        3'd4: f_code = MN_XOR;
                        3'd5: f_code = MN_SRL;
                        3'd6: f_code = MN_OR;
                        default: f_code = MN_AND;
                    endcase
                end
                else if (f7 == F7_MUL)
                begin
                    case (f3)
                        3'd0: f_code = MN_MUL;
                        3'd1: f_code = MN_MULH;
                        3'd2: f_code = MN_MULHSU;
                        3'd3: f_code = MN_MULHU;
                        3'd4: f_code = MN_DIV;
                        3'd5: f_code = MN_DIVU;
                        3'd6: f_code = MN_REM;
                        default: f_code = MN_REMU;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == 3'd0)
                    f_code = MN_SUB;
                else if (f7 == F7_ALT && f3 == 3'd5)
                    f_code = MN_SRA;
                else
                    f_code = MN_ILLEGAL;
            end
            OPC_LUI: f_code = MN_LUI;
            OPC_OP_32:
            begin
                case (f3)
                    3'd0:
                    begin
                        if (f7 == F7_BASE)
                            f_code = MN_ADDW;
                        else if (f7 == F7_MUL)
                            f_code = MN_MULW;
                        else if (f7 == F7_ALT)
                            f_code = MN_SUBW;
                        else
                            f_code = MN_ILLEGAL;
                    end
                    3'd1: f_code = MN_SLLW;
                    3'd4: f_code = (f7 == F7_MUL) ? MN_DIVW : MN_ILLEGAL;
                    3'd5:
                    begin
                        if (f7 == F7_BASE)
                            f_code = MN_SRLW;
                        else if (f7 == F7_MUL)
                            f_code = MN_DIVUW;
                        else if (f7 == F7_ALT)
                            f_code = MN_SRAW;
                        else
                            f_code = MN_ILLEGAL;
                    end
                    3'd6: f_code = (f7 == F7_MUL) ? MN_REMW : MN_ILLEGAL;
                    3'd7: f_code = (f7 == F7_MUL) ? MN_REMUW : MN_ILLEGAL;
                    default: f_code = MN_ILLEGAL;
                endcase
            end
            OPC_BRANCH:
            begin
                case (f3)
                    3'd0: f_code = MN_BEQ;
                    3'd1: f_code = MN_BNE;
                    3'd4: f_code = MN_BLT;
                    3'd5: f_code = MN_BGE;
                    3'd6: f_code = MN_BLTU;
                    3'd7: f_code = MN_BGEU;
                    default: f_code = MN_ILLEGAL;
                endcase
            end
            OPC_JALR: f_code = MN_JALR;
            OPC_JAL:  f_code = MN_JAL;
            OPC_SYSTEM:
            begin
                case (f3)
                    3'd0:
                    begin
                        case (instruction)
                            WORD_ECALL:  f_code = MN_ECALL;
                            WORD_EBREAK: f_code = MN_EBREAK;
                            WORD_URET:   f_code = MN_URET;
                            WORD_SRET:   f_code = MN_SRET;
                            WORD_HRET:   f_code = MN_HRET;
                            WORD_MRET:   f_code = MN_MRET;
                            default:     f_code = MN_ILLEGAL;
                        endcase
                    end
                    3'd1: f_code = MN_CSRRW;
                    3'd2: f_code = MN_CSRRS;
                    3'd3: f_code = MN_CSRRC;
                    3'd5: f_code = MN_CSRRWI;
                    3'd6: f_code = MN_CSRRSI;
                    3'd7: f_code = MN_CSRRCI;
                    default: f_code = MN_ILLEGAL;
                endcase
            end
            default: f_code = MN_UNKNOWN;
        endcase
    end

    assign result.compressed = (quad != QUAD_FULL);
    assign result.code       = (quad != QUAD_FULL) ? c_code : f_code;

endmodule

[hw/rtl/rv64_instruction_classifier_unit.sv]
// Top level of the RV64IMAC instruction classifier: handshake, pipeline registers, checks.
//
// Input channel: in_valid / in_stall with the 32-bit instruction word. A transfer
// happens at a rising edge where in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with mnemonic_code (0 illegal, 1 unknown
// major opcode, 2..137 mnemonics) and is_compressed (bits 1:0 of the word not 3).
//
// A word taken in is held in the input register, decoded, then held in the result register.
// Throughput: one word per cycle while out_stall is low; the decode sits between the
// input register and the result register, a single pass of shallow compare logic.
//
// Reset (rst_n low, asynchronous) empties both stages; no result is shown and
// in_stall drops low, so the block is ready from the first edge after release.
// When the receiver stalls, the result holds steady; the input register keeps
// filling until both stages are full, and only then in_stall rises. It falls
// in the same cycle out_stall does, so no bubble is lost.
`include "rv64_instruction_classifier_unit_macros.svh"

module rv64_instruction_classifier_unit
    import rv64ic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] instruction,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  mnemonic_code,
    output logic        is_compressed
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [31:0] instr_reg;
    logic [31:0] instr_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     result_reg;
    result_t     result_next;
    result_t     decoded;
    logic        s1_load;
    logic        s2_load;

    // Advance the result stage when it is empty or being taken; advance the
    // input stage when it is empty or moving on.
    assign s2_load = !out_valid_reg || !out_stall;
    assign s1_load = !s1_valid_reg || s2_load;

    assign in_stall = !s1_load;

    rv64ic_decode u_decode
    (
        .instruction (instr_reg),
        .result      (decoded)
    );

    always_comb
    begin
        s1_valid_next  = s1_load ? in_valid : s1_valid_reg;
        instr_next     = (s1_load && in_valid) ? instruction : instr_reg;
        out_valid_next = s2_load ? s1_valid_reg : out_valid_reg;
        result_next    = (s2_load && s1_valid_reg) ? decoded : result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: hold unless a transfer moves new data in.
    always_ff @(posedge clk)
    begin
        instr_reg  <= instr_next;
        result_reg <= result_next;
    end

    assign out_valid     = out_valid_reg;
    assign mnemonic_code = result_reg.code;
    assign is_compressed = result_reg.compressed;

    // Back-pressure reaches the input only when both stages are full and stalled.
    `RV64IC_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall,
        s1_valid_reg && out_valid_reg && out_stall)

    // An accepted word lands in the input stage.
    `RV64IC_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_valid && !in_stall, s1_valid_reg)

    // Compressed results carry only compressed or illegal codes.
    `RV64IC_ASSERT_NOW(a_comp_code_range, clk, rst_n, out_valid && is_compressed,
        mnemonic_code <= MN_C_SDSP && mnemonic_code != MN_UNKNOWN)

    // Full-width results never carry a compressed mnemonic code.
    `RV64IC_ASSERT_NOW(a_full_code_range, clk, rst_n, out_valid && !is_compressed,
        mnemonic_code == MN_ILLEGAL || mnemonic_code == MN_UNKNOWN ||
        (mnemonic_code >= MN_LB && mnemonic_code <= MN_CSRRCI))

endmodule
